FILE: hw/rtl/bfl_pkg.sv
`default_nettype none

package bfl_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);

  localparam int TOTAL_MAX_I = (NUM_BLOCKS < (1 << IDX_W)) ? NUM_BLOCKS : (1 << IDX_W);

  localparam logic [CNT_W-1:0] TOTAL_MAX   = CNT_W'(TOTAL_MAX_I);
  localparam logic [CNT_W-1:0] TOTAL_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  localparam logic [1:0] REQ_FORMAT = 2'd0;
  localparam logic [1:0] REQ_ALLOC  = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] block_index;
  } bfl_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_block;
    logic [1:0]       status;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } bfl_out_t;

  typedef struct packed {
    logic load;
    logic fmt_init;
    logic fmt_step;
    logic commit;
  } bfl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       fmt_last;
    logic       out_free;
  } bfl_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bfl_ram.sv
`default_nettype none

module bfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bfl_ctrl.sv
`default_nettype none

module bfl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bfl_pkg::bfl_stat_t stat,
  output bfl_pkg::bfl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FMT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.req_type == bfl_pkg::REQ_FORMAT) begin
          cmd.fmt_init = 1'b1;
          state_nxt    = S_FMT;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FMT: begin
        cmd.fmt_step = 1'b1;
        if (stat.fmt_last && stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bfl_dp.sv
`default_nettype none

module bfl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bfl_pkg::bfl_in_t            in_data,
  input  wire logic                        cfg_valid,
  input  wire logic [bfl_pkg::CNT_W-1:0]   cfg_data,
  input  wire bfl_pkg::bfl_cmd_t           cmd,
  output bfl_pkg::bfl_stat_t               stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bfl_pkg::bfl_out_t                out_data
);

  logic [1:0]                  req_r;
  logic [bfl_pkg::IDX_W-1:0]   idx_r;
  logic [bfl_pkg::CNT_W-1:0]   total_cfg_r;
  logic [bfl_pkg::CNT_W-1:0]   total_lat_r;
  logic [bfl_pkg::CNT_W-1:0]   total_lat_nxt;
  logic [bfl_pkg::IDX_W-1:0]   head_r;
  logic [bfl_pkg::IDX_W-1:0]   head_nxt;
  logic [bfl_pkg::CNT_W-1:0]   used_r;
  logic [bfl_pkg::CNT_W-1:0]   used_nxt;
  logic [bfl_pkg::IDX_W-1:0]   cnt_r;
  logic [bfl_pkg::CNT_W-1:0]   fmt_total_r;
  logic [bfl_pkg::CNT_W-1:0]   clamped;
  logic                        fmt_last;
  logic                        idx_bad;
  logic                        out_valid_r;
  bfl_pkg::bfl_out_t           out_data_r;
  bfl_pkg::bfl_out_t           res;
  logic                        ram_we;
  logic [bfl_pkg::ADDR_W-1:0]  ram_waddr;
  logic [bfl_pkg::IDX_W-1:0]   ram_wdata;
  logic [bfl_pkg::IDX_W-1:0]   ram_rdata;

  bfl_ram #(
    .WIDTH (bfl_pkg::IDX_W),
    .DEPTH (bfl_pkg::NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bfl_pkg::ADDR_W'(head_r)),
    .rdata (ram_rdata)
  );

  always_comb begin
    clamped = total_cfg_r;
    if (clamped < bfl_pkg::TOTAL_MIN) begin
      clamped = bfl_pkg::TOTAL_MIN;
    end
    if (clamped > bfl_pkg::TOTAL_MAX) begin
      clamped = bfl_pkg::TOTAL_MAX;
    end
  end

  assign fmt_last = ({1'b0, cnt_r} + bfl_pkg::CNT_W'(1)) >= fmt_total_r;
  assign idx_bad  = (idx_r == '0) || ({1'b0, idx_r} >= total_lat_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bfl_pkg::ADDR_W'(cnt_r);
    ram_wdata = fmt_last ? '0 : cnt_r + bfl_pkg::IDX_W'(1);
    if (cmd.fmt_step) begin
      ram_we = 1'b1;
    end else if (cmd.commit && req_r == bfl_pkg::REQ_FREE && !idx_bad) begin
      ram_we    = 1'b1;
      ram_waddr = bfl_pkg::ADDR_W'(idx_r);
      ram_wdata = head_r;
    end
  end

  always_comb begin
    head_nxt          = head_r;
    used_nxt          = used_r;
    total_lat_nxt     = total_lat_r;
    res.granted_block = '0;
    res.status        = bfl_pkg::ST_OK;
    case (req_r)
      bfl_pkg::REQ_FORMAT: begin
        head_nxt      = bfl_pkg::IDX_W'(1);
        used_nxt      = bfl_pkg::CNT_W'(1);
        total_lat_nxt = fmt_total_r;
      end
      bfl_pkg::REQ_ALLOC: begin
        if (head_r == '0) begin
          res.status = bfl_pkg::ST_EMPTY;
        end else begin
          res.granted_block = head_r;
          head_nxt          = ram_rdata;
          if (used_r != bfl_pkg::CNT_MAX) begin
            used_nxt = used_r + bfl_pkg::CNT_W'(1);
          end
        end
      end
      bfl_pkg::REQ_FREE: begin
        if (idx_bad) begin
          res.status = bfl_pkg::ST_RANGE;
        end else begin
          head_nxt = idx_r;
          if (used_r != '0) begin
            used_nxt = used_r - bfl_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.used_count = used_nxt;
    res.free_count = (total_lat_nxt > used_nxt) ? total_lat_nxt - used_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_cfg_r <= bfl_pkg::TOTAL_RESET;
      total_lat_r <= '0;
      head_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        total_cfg_r <= cfg_data;
      end
      if (cmd.commit) begin
        total_lat_r <= total_lat_nxt;
        head_r      <= head_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data.req_type;
      idx_r <= in_data.block_index;
    end
    if (cmd.fmt_init) begin
      cnt_r       <= bfl_pkg::IDX_W'(1);
      fmt_total_r <= clamped;
    end else if (cmd.fmt_step && !fmt_last) begin
      cnt_r <= cnt_r + bfl_pkg::IDX_W'(1);
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign stat.req_type = req_r;
  assign stat.fmt_last = fmt_last;
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/block_free_list_allocator.sv
// Channel  Ports                            Beat carries
// in       in_valid, in_ready, in_data      one request (type, block index)
// out      out_valid, out_ready, out_data   one result (block, status, counts)
// cfg      cfg_valid, cfg_ready, cfg_data   total block count
//
// Allocate, free and the unused request code take the beat, then write the
// result once the head block's link is out of the link RAM and out has room.
// Format writes one link per cycle into the link RAM.
// Reset is synchronous and active low; the link RAM is not cleared.
// A result waits in the output register while out_ready is low and holds
// the next request until it has room.
`default_nettype none

module block_free_list_allocator (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire bfl_pkg::bfl_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output bfl_pkg::bfl_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bfl_pkg::CNT_W-1:0] cfg_data
);

  bfl_pkg::bfl_cmd_t  cmd;
  bfl_pkg::bfl_stat_t stat;

  assign cfg_ready = 1'b1;

  bfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bfl_checker.sv
`default_nettype none

module bfl_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire bfl_pkg::bfl_out_t         out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.granted_block != '0 |-> out_data.status == bfl_pkg::ST_OK)
    else $error("block granted with a failure status");

  a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bfl_pkg::ST_EMPTY |-> out_data.granted_block == '0)
    else $error("block granted from an empty list");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.free_count != '0 |->
      ({1'b0, out_data.used_count} + {1'b0, out_data.free_count})
        <= {1'b0, bfl_pkg::TOTAL_MAX})
    else $error("used and free counts exceed the block total");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule

bind block_free_list_allocator bfl_checker u_bfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
  import bfl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STEP_COUNT = 27;

  typedef struct packed {
    bit               is_cfg;
    logic [CNT_W-1:0] cfg_val;
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
    bit               typed;
    bfl_out_t         want;
  } step_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bfl_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bfl_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  block_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted allocator state.
  logic [IDX_W-1:0] link_mem [NUM_BLOCKS];
  logic [IDX_W-1:0] head_blk;
  logic [CNT_W-1:0] blocks_used;
  logic [CNT_W-1:0] fmt_total;
  logic [CNT_W-1:0] cfg_total;

  bfl_out_t         pending_results [$];
  logic [IDX_W-1:0] granted_blocks [$];
  step_t            directed_tbl [STEP_COUNT];

  int n_fail;
  int stall_left;
  bit idle_on;
  bit hold_req;
  bit hold_done;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bfl_out_t allocator_predict(input logic [1:0] req,
                                                 input logic [IDX_W-1:0] idx);
    bfl_out_t r;
    logic [CNT_W-1:0] t;
    int i;
    r = '0;
    case (req)
      REQ_FORMAT: begin
        t = cfg_total;
        if (t < TOTAL_MIN) t = TOTAL_MIN;
        if (t > TOTAL_MAX) t = TOTAL_MAX;
        for (i = 1; i < int'(t); i++) begin
          link_mem[i] = (i + 1 < int'(t)) ? IDX_W'(i + 1) : '0;
        end
        fmt_total   = t;
        head_blk    = IDX_W'(1);
        blocks_used = CNT_W'(1);
      end
      REQ_ALLOC: begin
        if (head_blk == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted_block = head_blk;
          head_blk = link_mem[head_blk];
          if (blocks_used != CNT_MAX) blocks_used = blocks_used + CNT_W'(1);
        end
      end
      REQ_FREE: begin
        if (idx == '0 || {1'b0, idx} >= fmt_total) begin
          r.status = ST_RANGE;
        end else begin
          link_mem[idx] = head_blk;
          head_blk = idx;
          if (blocks_used != '0) blocks_used = blocks_used - CNT_W'(1);
        end
      end
      default: ;
    endcase
    r.used_count = blocks_used;
    r.free_count = (fmt_total > blocks_used) ? fmt_total - blocks_used : '0;
    return r;
  endfunction

  function automatic step_t row_chk(input logic [1:0] req, input int idx, input int blk,
                                    input logic [1:0] st, input int used, input int free);
    step_t s;
    s = '0;
    s.req   = req;
    s.idx   = IDX_W'(idx);
    s.typed = 1'b1;
    s.want  = bfl_out_t'{IDX_W'(blk), st, CNT_W'(used), CNT_W'(free)};
    return s;
  endfunction

  function automatic step_t row_req(input logic [1:0] req, input int idx);
    step_t s;
    s = '0;
    s.req = req;
    s.idx = IDX_W'(idx);
    return s;
  endfunction

  function automatic step_t row_cfg(input int val);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = CNT_W'(val);
    return s;
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                              input bit typed, input bfl_out_t typed_res,
                              output bfl_out_t res);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= bfl_in_t'{req, idx};
    do @(posedge clk); while (!in_ready);
    res = allocator_predict(req, idx);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_total(input logic [CNT_W-1:0] val);
    wait_drained(4);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_total = val;
  endtask

  task automatic check_result(input bfl_out_t got);
    bfl_out_t want;
    if (pending_results.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("Unexpected result beat: blk %0d st %0d used %0d free %0d",
                 got.granted_block, got.status, got.used_count, got.free_count);
    end else begin
      want = pending_results.pop_front();
      if (got.granted_block !== want.granted_block || got.status !== want.status ||
          got.used_count !== want.used_count || got.free_count !== want.free_count) begin
        n_fail++;
        if (n_fail <= 10)
          $display({"Mismatch: got blk %0d st %0d used %0d free %0d, ",
                    "want blk %0d st %0d used %0d free %0d"},
                   got.granted_block, got.status, got.used_count, got.free_count,
                   want.granted_block, want.status, want.used_count, want.free_count);
      end
    end
  endtask

  // Result side: checks each beat and inserts stalls, including one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_req && !hold_done) begin
        hold_done  <= 1'b1;
        stall_left <= 80;
        out_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    int n;
    int p;
    int roll;
    int pick;
    bfl_out_t res;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] tot;
    logic [CNT_W-1:0] phase_totals [10];

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    n_fail      = 0;
    stall_left  = 0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    head_blk    = '0;
    blocks_used = '0;
    fmt_total   = '0;
    cfg_total   = TOTAL_RESET;
    for (k = 0; k < NUM_BLOCKS; k++) link_mem[k] = '0;

    directed_tbl = '{
      row_chk(REQ_ALLOC, 0, 0, ST_EMPTY, 0, 0),
      row_chk(REQ_FREE, 5, 0, ST_RANGE, 0, 0),
      row_chk(REQ_UNUSED, 0, 0, ST_OK, 0, 0),
      row_cfg(2),
      row_chk(REQ_FORMAT, 0, 0, ST_OK, 1, 1),
      row_chk(REQ_ALLOC, 0, 1, ST_OK, 2, 0),
      row_chk(REQ_ALLOC, 0, 0, ST_EMPTY, 2, 0),
      row_chk(REQ_FREE, 1, 0, ST_OK, 1, 1),
      row_chk(REQ_FREE, 2, 0, ST_RANGE, 1, 1),
      row_chk(REQ_FREE, 0, 0, ST_RANGE, 1, 1),
      row_cfg(0),
      row_chk(REQ_FORMAT, 0, 0, ST_OK, 1, 1),
      row_cfg(2047),
      row_chk(REQ_FORMAT, 0, 0, ST_OK, 1, 1023),
      row_chk(REQ_ALLOC, 0, 1, ST_OK, 2, 1022),
      row_chk(REQ_FREE, 1023, 0, ST_OK, 1, 1023),
      row_chk(REQ_FREE, 1023, 0, ST_OK, 0, 1024),
      row_chk(REQ_FREE, 1023, 0, ST_OK, 0, 1024),
      row_chk(REQ_ALLOC, 0, 1023, ST_OK, 1, 1023),
      row_chk(REQ_ALLOC, 0, 1023, ST_OK, 2, 1022),
      row_chk(REQ_UNUSED, 1023, 0, ST_OK, 2, 1022),
      row_cfg(1),
      row_chk(REQ_FORMAT, 0, 0, ST_OK, 1, 1),
      row_req(REQ_ALLOC, 0),
      row_req(REQ_FREE, 1),
      row_cfg(1024),
      row_req(REQ_FORMAT, 0)
    };

    phase_totals = '{11'd5, 11'd1024, 11'd3, 11'd1025, 11'd2,
                     11'd40, 11'd1, 11'd12, 11'd700, 11'd9};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < STEP_COUNT; k++) begin
      if (directed_tbl[k].is_cfg) begin
        set_total(directed_tbl[k].cfg_val);
      end else begin
        send_request(directed_tbl[k].req, directed_tbl[k].idx, directed_tbl[k].typed,
                     directed_tbl[k].want, res);
      end
    end

    // A double free of block 1 with a total of two makes the list loop on itself,
    // so allocation never runs dry and the used count keeps climbing.
    set_total(CNT_W'(2));
    send_request(REQ_FORMAT, '0, 1'b0, '0, res);
    send_request(REQ_ALLOC, '0, 1'b0, '0, res);
    send_request(REQ_FREE, IDX_W'(1), 1'b0, '0, res);
    send_request(REQ_FREE, IDX_W'(1), 1'b0, '0, res);
    repeat (20) send_request(REQ_ALLOC, '0, 1'b0, '0, res);
    repeat (2) send_request(REQ_FREE, IDX_W'(1), 1'b0, '0, res);

    for (p = 0; p < 10; p++) begin
      if (p == 8) idle_on <= 1'b0;
      tot = (p == 6) ? CNT_W'($urandom_range(0, 2047)) : phase_totals[p];
      set_total(tot);
      if (p != 5) begin
        send_request(REQ_FORMAT, IDX_W'($urandom_range(0, 1023)), 1'b0, '0, res);
        granted_blocks.delete();
      end
      for (n = 0; n < 120; n++) begin
        if (p == 1 && n == 30) hold_req <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          send_request(REQ_FORMAT, IDX_W'($urandom_range(0, 1023)), 1'b0, '0, res);
          granted_blocks.delete();
        end else if (roll < 6) begin
          send_request(REQ_UNUSED, IDX_W'($urandom_range(0, 1023)), 1'b0, '0, res);
        end else if (roll < 14) begin
          idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 1023))
                                     : IDX_W'($urandom_range(0, int'(fmt_total)));
          send_request(REQ_FREE, idx, 1'b0, '0, res);
        end else if (roll < 55 && granted_blocks.size() > 0) begin
          pick = $urandom_range(0, granted_blocks.size() - 1);
          idx  = granted_blocks[pick];
          granted_blocks.delete(pick);
          send_request(REQ_FREE, idx, 1'b0, '0, res);
        end else begin
          send_request(REQ_ALLOC, IDX_W'($urandom_range(0, 1023)), 1'b0, '0, res);
          if (res.status == ST_OK) granted_blocks.push_back(res.granted_block);
        end
      end
    end

    wait_drained(20);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
